>>> design/erud_pkg.sv
package erud_pkg;

	localparam int ROWS_DEF = 1024;
	localparam int DIM_DEF  = 128;

	localparam int FUNC_W    = 2;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 7;
	localparam int WORD_W    = 32;
	localparam int PROD_W    = 64;
	// Q16.48 rounded to Q8.24 keeps 41 significant bits
	localparam int RND_W     = 41;
	localparam int SUM_W     = 42;

	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_DOT    = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic signed [WORD_W-1:0] operand;
		logic signed [WORD_W-1:0] scale;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     done_res;
		logic                     saturated;
	} res_t;

	typedef struct packed {
		logic load;     // take the accepted word
		logic rd;       // read the table entry
		logic wr_item;  // store operand into the table
		logic mul;      // form the product
		logic acc;      // add product into the dot accumulator
		logic rnd;      // round product or accumulator to Q8.24
		logic rnd_acc;  // round source is the accumulator
		logic sum;      // final add and saturate
		logic emit;     // load the result register
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              last;
		logic              out_free;
	} sts_t;

endpackage

>>> design/erud_ram.sv
module erud_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/erud_ctrl.sv
module erud_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  erud_pkg::sts_t  sts,
	output erud_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.func == erud_pkg::FUNC_WRITE) begin
					cmd.wr_item = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = (sts.func == erud_pkg::FUNC_DOT) ? ST_ACC : ST_RND;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_RND : ST_EMIT;
			end
			ST_RND: begin
				cmd.rnd     = 1'b1;
				cmd.rnd_acc = (sts.func == erud_pkg::FUNC_DOT);
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/erud_dp.sv
module erud_dp #(
	parameter int ROWS = erud_pkg::ROWS_DEF,
	parameter int DIM  = erud_pkg::DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  erud_pkg::item_t item,
	input  erud_pkg::cmd_t  cmd,
	output erud_pkg::sts_t  sts,
	output logic            res_valid,
	input  logic            res_stall,
	output erud_pkg::res_t  res
);

	localparam int DEPTH = ROWS * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW    = erud_pkg::WORD_W;
	localparam int PW    = erud_pkg::PROD_W;
	localparam int RW    = erud_pkg::RND_W;
	localparam int SW    = erud_pkg::SUM_W;

	localparam logic signed [SW-1:0] MAX32 = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] MIN32 = -SW'(64'sd2147483648);

	// item held for the whole operation
	erud_pkg::item_t item_q;
	logic [AW-1:0]   addr_q;
	logic            ok_q;

	logic signed [WW-1:0] elem_q;
	logic signed [PW-1:0] prod_q;
	logic signed [RW-1:0] rnd_q;
	logic signed [PW-1:0] acc_q;
	logic                 ovf_q;

	logic signed [WW-1:0] val_q;
	logic                 done_q;
	logic                 sat_q;

	logic                 out_valid_q;
	erud_pkg::res_t       out_q;

	logic [AW-1:0]        addr_d;
	logic                 ok_d;
	logic [WW-1:0]        rdata;
	logic                 ram_we;
	logic [WW-1:0]        ram_wdata;
	logic signed [WW-1:0] elem;
	logic signed [WW-1:0] mul_a;
	logic signed [WW-1:0] mul_b;
	logic signed [PW-1:0] rnd_src;
	logic signed [RW-1:0] rnd_d;
	logic signed [RW+1:0] rnd_t;
	logic signed [WW-1:0] addend;
	logic signed [SW-1:0] sum_full;
	logic signed [WW-1:0] sum_sat;
	logic                 sum_flag;
	logic signed [PW:0]   acc_full;

	// out of range only for non-default shapes; such an element reads as zero
	assign ok_d   = (32'(item.row) < 32'(ROWS)) && (32'(item.col) < 32'(DIM));
	assign addr_d = AW'(item.row) * AW'(DIM) + AW'(item.col);

	assign ram_we    = ok_q && (cmd.wr_item ||
		(cmd.sum && (item_q.func == erud_pkg::FUNC_UPDATE)));
	assign ram_wdata = cmd.wr_item ? item_q.operand : sum_sat;

	erud_ram #(
		.WIDTH (WW),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign elem = ok_q ? $signed(rdata) : '0;

	always_comb begin
		case (item_q.func)
			erud_pkg::FUNC_UPDATE: begin
				mul_a = item_q.scale;
				mul_b = item_q.operand;
			end
			erud_pkg::FUNC_READ: begin
				mul_a = item_q.scale;
				mul_b = elem;
			end
			default: begin
				mul_a = elem;
				mul_b = item_q.operand;
			end
		endcase
	end

	// round to nearest, ties up: floor((floor(v / 2^23) + 1) / 2)
	assign rnd_src = cmd.rnd_acc ? acc_q : prod_q;
	assign rnd_t   = (RW+2)'($signed(rnd_src[PW-1:23])) + (RW+2)'(1);
	assign rnd_d   = rnd_t[RW:1];

	always_comb begin
		case (item_q.func)
			erud_pkg::FUNC_UPDATE: addend = elem_q;
			erud_pkg::FUNC_READ:   addend = item_q.operand;
			default:               addend = '0;
		endcase
	end

	assign sum_full = SW'(addend) + SW'(rnd_q);

	always_comb begin
		sum_flag = 1'b0;
		sum_sat  = sum_full[WW-1:0];
		if (sum_full > MAX32) begin
			sum_flag = 1'b1;
			sum_sat  = MAX32[WW-1:0];
		end else if (sum_full < MIN32) begin
			sum_flag = 1'b1;
			sum_sat  = MIN32[WW-1:0];
		end
	end

	assign acc_full = (PW+1)'(acc_q) + (PW+1)'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			addr_q <= addr_d;
			ok_q   <= ok_d;
		end
		if (cmd.mul) begin
			elem_q <= elem;
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (cmd.rnd) begin
			rnd_q <= rnd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc) begin
			// clamp on signed overflow of the 64-bit sum
			if (acc_full[PW] != acc_full[PW-1]) begin
				acc_q <= acc_full[PW] ? {1'b1, {(PW-1){1'b0}}}
					: {1'b0, {(PW-1){1'b1}}};
				ovf_q <= 1'b1;
			end else begin
				acc_q <= acc_full[PW-1:0];
			end
		end else if (cmd.sum && (item_q.func == erud_pkg::FUNC_DOT)) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else if (cmd.load) begin
			val_q  <= '0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else if (cmd.acc) begin
			sat_q <= ovf_q || (acc_full[PW] != acc_full[PW-1]);
		end else if (cmd.sum) begin
			val_q  <= (item_q.func == erud_pkg::FUNC_UPDATE) ? '0 : sum_sat;
			done_q <= (item_q.func == erud_pkg::FUNC_DOT);
			sat_q  <= sum_flag || ((item_q.func == erud_pkg::FUNC_DOT) && ovf_q);
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.value     <= val_q;
			out_q.done_res  <= done_q;
			out_q.saturated <= sat_q;
		end
	end

	assign res_valid    = out_valid_q;
	assign res          = out_q;
	assign sts.func     = item_q.func;
	assign sts.last     = item_q.last;
	assign sts.out_free = !out_valid_q || !res_stall;

endmodule

>>> design/embedding_row_update_and_dot.sv
// Embedding table of ROWS x DIM signed Q8.24 words in one RAM, addressed by
// row * DIM + col. A word names a function: write stores the operand; update
// adds round(scale * operand) to the element; read returns operand +
// round(scale * element); dot adds element * operand into a saturating
// Q16.48 accumulator and, on the word marked last, returns it rounded to
// Q8.24 and clears it. Every sum saturates and sets the saturated flag.
// One word is in flight at a time; the next is accepted once its walk ends:
// write stores into the table; update and read pass the table RAM read, the
// registered 32x32 multiplier, the rounding stage and the final add; a dot
// word passes the RAM read, the multiplier and the accumulate, the last one
// also the rounding and final add; the result register waits on res_stall.
// Entries read before they are written return undefined data.
module embedding_row_update_and_dot #(
	parameter int ROWS = erud_pkg::ROWS_DEF,
	parameter int DIM  = erud_pkg::DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  erud_pkg::item_t item,
	output logic            res_valid,
	input  logic            res_stall,
	output erud_pkg::res_t  res
);

	erud_pkg::cmd_t cmd;
	erud_pkg::sts_t sts;

	erud_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	erud_dp #(
		.ROWS (ROWS),
		.DIM  (DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
